### hw/rtl/sre_pkg.sv
// Package for the simple regex stream matcher.
// Holds the pattern limits, the special byte codes, the operation and register codes,
// and the per-position types shared by the decoder, the cells and the top level.
package sre_pkg;

  // Pattern storage: sixteen byte positions plus one end position
  localparam int unsigned MaxPattern = 16;
  localparam int unsigned NumCells   = MaxPattern + 1;
  localparam int unsigned LenW       = 5;

  // Special pattern bytes
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChCaret  = 8'h5E;

  // Input operation codes
  typedef enum logic {
    OpByte = 1'b0,
    OpEnd  = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgFirstBytes = 2'd0,
    CfgLastBytes  = 2'd1,
    CfgLength     = 2'd2
  } cfg_idx_e;

  // Decoded view of one pattern position
  typedef struct packed {
    logic [7:0] pat_byte; // pattern byte at this position
    logic       live;     // position lies inside the pattern
    logic       star;     // next byte is a star, this byte repeats
    logic       fdollar;  // final dollar anchor
    logic       at_end;   // position equals the pattern length
    logic       keep;     // position survives the length mask
  } cell_attr_t;

  // What one cell hands on to its neighbours
  typedef struct packed {
    logic skip; // zero-length star: position two further is reachable
    logic adv;  // byte matched: next position is live for the next byte
  } cell_link_t;

  // Per-cell status gathered by the top level
  typedef struct packed {
    logic end_hit;    // pattern end reached
    logic dollar_hit; // final dollar position reached
  } cell_stat_t;

endpackage

### hw/rtl/sre_decode.sv
// Pattern decoder for the simple regex stream matcher.
// Turns the configuration registers into per-position attributes for the cell row.
// Depends on sre_pkg.
module sre_decode (
  input  logic [63:0]                                     first_bytes_i,
  input  logic [63:0]                                     last_bytes_i,
  input  logic [sre_pkg::LenW-1:0]                        length_i,
  output sre_pkg::cell_attr_t [sre_pkg::NumCells-1:0]     attr_o,
  output logic                                            anchored_o
);

  logic [sre_pkg::LenW-1:0]      len_sat;
  logic [7:0]                    pat [sre_pkg::MaxPattern];
  logic [sre_pkg::NumCells-1:0]  live;

  // Saturate the length at the pattern capacity
  assign len_sat = (length_i > sre_pkg::LenW'(sre_pkg::MaxPattern))
                 ? sre_pkg::LenW'(sre_pkg::MaxPattern) : length_i;

  // Unpack the bytes and find where the pattern ends (length or first zero byte)
  always_comb begin
    for (int k = 0; k < sre_pkg::MaxPattern; k++) begin
      if (k < 8) pat[k] = first_bytes_i[8*k +: 8];
      else       pat[k] = last_bytes_i[8*(k-8) +: 8];
    end
    live = '0;
    for (int k = 0; k < sre_pkg::MaxPattern; k++) begin
      live[k] = (sre_pkg::LenW'(k) < len_sat) && (pat[k] != 8'h00)
              && ((k == 0) || live[(k == 0) ? 0 : k-1]);
    end
  end

  // Per-position attributes
  always_comb begin
    for (int k = 0; k < sre_pkg::NumCells; k++) begin
      attr_o[k].pat_byte = (k < sre_pkg::MaxPattern) ? pat[(k < sre_pkg::MaxPattern) ? k : 0]
                                                     : 8'h00;
      attr_o[k].live     = live[k];
      attr_o[k].star     = '0;
      attr_o[k].fdollar  = '0;
      if (k < sre_pkg::MaxPattern) begin
        attr_o[k].star    = live[k+1] && (attr_o[k].pat_byte == 8'h00 ? 1'b0 : 1'b1)
                          && (pat[(k+1 < sre_pkg::MaxPattern) ? k+1 : 0] == sre_pkg::ChStar)
                          && (k+1 < sre_pkg::MaxPattern);
        attr_o[k].fdollar = live[k] && !live[k+1] && (pat[k] == sre_pkg::ChDollar);
      end
      if (k == 0) begin
        attr_o[k].at_end = !live[0];
        attr_o[k].keep   = 1'b1;
      end else begin
        attr_o[k].at_end = live[(k == 0) ? 0 : k-1] && !live[k];
        attr_o[k].keep   = live[(k == 0) ? 0 : k-1];
      end
    end
  end

  // A leading caret anchors the match at the start of the text
  assign anchored_o = live[0] && (pat[0] == sre_pkg::ChCaret);

endmodule

### hw/rtl/sre_cell.sv
// One pattern position of the matcher row.
// Holds the position's active bit and passes star skips and byte advances along the row.
// Depends on sre_pkg.
module sre_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sre_pkg::cell_attr_t  attr_i,
  input  logic [7:0]           text_byte_i,
  input  logic                 inject_i,  // start position for this text byte
  input  logic                 step_i,    // text byte accepted
  input  logic                 clear_i,   // end of text accepted
  input  logic                 skip_i,    // from the cell two positions back
  input  logic                 adv_i,     // from the previous cell
  output sre_pkg::cell_link_t  link_o,
  output sre_pkg::cell_stat_t  stat_o
);

  logic act_q, act_d;
  logic cur, closed, hit, adv_self;

  // Current set bit, closed over zero-length stars
  assign cur    = (act_q && attr_i.keep) || inject_i;
  assign closed = cur || skip_i;
  assign hit    = (attr_i.pat_byte == sre_pkg::ChDot) || (attr_i.pat_byte == text_byte_i);

  assign link_o.skip = closed && attr_i.live && attr_i.star;
  assign link_o.adv  = closed && attr_i.live && !attr_i.star && !attr_i.fdollar && hit;
  assign adv_self    = closed && attr_i.live && attr_i.star && hit;

  assign stat_o.end_hit    = closed && attr_i.at_end;
  assign stat_o.dollar_hit = closed && attr_i.live && attr_i.fdollar;

  // Next active bit
  always_comb begin
    act_d = act_q;
    if (clear_i)     act_d = 1'b0;
    else if (step_i) act_d = adv_self || adv_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) act_q <= 1'b0;
    else         act_q <= act_d;
  end

endmodule

### hw/rtl/simple_regex_stream_matcher_unit.sv
// Simple regex stream matcher, top level: registers, cell row, result register.
// Throughput: one transaction per cycle unless an untaken result stalls the input;
// the whole row updates on each text byte. The result reaches the output register
// in the cycle after end of text; a held result being taken does not stop input.
// Reset: pattern registers, active positions and flags clear, no result pending.
// Depends on sre_pkg, sre_decode and sre_cell.
module simple_regex_stream_matcher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // text input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  text_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        matched_o
);

  localparam int unsigned N = sre_pkg::NumCells;

  logic [63:0]                 first_bytes_q, last_bytes_q;
  logic [sre_pkg::LenW-1:0]    length_q;
  logic                        text_started_q, text_started_d;
  logic                        match_seen_q, match_seen_d;
  logic                        out_valid_q, out_valid_d;
  logic                        matched_q, matched_d;

  sre_pkg::cell_attr_t [N-1:0] attr;
  sre_pkg::cell_link_t [N-1:0] link;
  sre_pkg::cell_stat_t [N-1:0] stat;
  logic                        anchored;
  logic [N-1:0]                inject, end_hits, dollar_hits;
  logic                        accept, step, clear, end_any, dollar_any;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_bytes_q <= '0;
      last_bytes_q  <= '0;
      length_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (sre_pkg::cfg_idx_e'(cfg_index_i))
        sre_pkg::CfgFirstBytes: first_bytes_q <= cfg_data_i;
        sre_pkg::CfgLastBytes:  last_bytes_q  <= cfg_data_i;
        sre_pkg::CfgLength:     length_q      <= cfg_data_i[sre_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // Pattern decode
  sre_decode u_decode (
    .first_bytes_i (first_bytes_q),
    .last_bytes_i  (last_bytes_q),
    .length_i      (length_q),
    .attr_o        (attr),
    .anchored_o    (anchored)
  );

  // Input handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign step       = accept && (sre_pkg::op_e'(op_i) == sre_pkg::OpByte);
  assign clear      = accept && (sre_pkg::op_e'(op_i) == sre_pkg::OpEnd);

  // Start positions: every byte when unanchored, first byte only after a caret
  always_comb begin
    inject    = '0;
    inject[0] = !anchored;
    inject[1] = anchored && !text_started_q;
  end

  // Cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic skip_in, adv_in;
    if (i >= 2) begin : g_skip
      assign skip_in = link[i-2].skip;
    end else begin : g_noskip
      assign skip_in = 1'b0;
    end
    if (i >= 1) begin : g_adv
      assign adv_in = link[i-1].adv;
    end else begin : g_noadv
      assign adv_in = 1'b0;
    end

    sre_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .attr_i      (attr[i]),
      .text_byte_i (text_byte_i),
      .inject_i    (inject[i]),
      .step_i      (step),
      .clear_i     (clear),
      .skip_i      (skip_in),
      .adv_i       (adv_in),
      .link_o      (link[i]),
      .stat_o      (stat[i])
    );

    assign end_hits[i]    = stat[i].end_hit;
    assign dollar_hits[i] = stat[i].dollar_hit;
  end

  assign end_any    = |end_hits;
  assign dollar_any = |dollar_hits;

  // Text flags and result register
  always_comb begin
    text_started_d = text_started_q;
    match_seen_d   = match_seen_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    matched_d      = matched_q;
    if (step) begin
      text_started_d = 1'b1;
      match_seen_d   = match_seen_q || end_any;
    end else if (clear) begin
      text_started_d = 1'b0;
      match_seen_d   = 1'b0;
      out_valid_d    = 1'b1;
      matched_d      = match_seen_q || end_any || dollar_any;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_started_q <= 1'b0;
      match_seen_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      text_started_q <= text_started_d;
      match_seen_q   <= match_seen_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

  // Checks
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> out_valid_q)
    else $error("end of text did not produce a result");

  a_end_clears_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (!text_started_q && !match_seen_q))
    else $error("text flags not cleared after end of text");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_q && !out_ready_i))
    else $error("input stalled without a pending result");

  a_empty_pattern_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clear && !attr[0].live) |=> matched_q)
    else $error("empty pattern failed to match");

endmodule

### bench/tb.sv
// Self-checking bench for simple_regex_stream_matcher_unit.
// Streams text transactions against stored patterns and checks every match verdict.
// Depends on sre_pkg and the matcher RTL only.
`timescale 1ns / 1ps

module tb;

  localparam int NumPhases  = 12;
  localparam int PhaseItems = 152;
  localparam int HoldCycles = 400;
  localparam int CycleLimit = 200000;

  // Directed stimulus rows: register writes and text transactions
  typedef enum logic {
    RowItem = 1'b0,
    RowCfg  = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    sre_pkg::cfg_idx_e  idx;
    logic [63:0]        data;
    sre_pkg::op_e       op;
    logic [7:0]         tbyte;
    logic               typed; // verdict given in the row, not predicted
    logic               want;
  } dir_row_t;

  localparam int NumDir = 30;
  localparam dir_row_t DirRows [NumDir] = '{
    // empty pattern straight after reset matches the empty text
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpEnd, 8'h00, 1'b1, 1'b1},
    // "^a*b$"
    '{RowCfg, sre_pkg::CfgFirstBytes, 64'h0000_0024_622A_615E,
      sre_pkg::OpByte, 8'h00, 1'b0, 1'b0},
    '{RowCfg, sre_pkg::CfgLength, 64'd5, sre_pkg::OpByte, 8'h00, 1'b0, 1'b0},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpByte, 8'h61, 1'b0, 1'b0},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpByte, 8'h61, 1'b0, 1'b0},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpByte, 8'h62, 1'b0, 1'b0},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpEnd, 8'h00, 1'b1, 1'b1},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpEnd, 8'h00, 1'b1, 1'b0},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpByte, 8'h61, 1'b0, 1'b0},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpByte, 8'h62, 1'b0, 1'b0},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpByte, 8'h63, 1'b0, 1'b0},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpEnd, 8'h00, 1'b1, 1'b0},
    // "x.*y", a zero text byte swallowed by the dot-star
    '{RowCfg, sre_pkg::CfgFirstBytes, 64'h0000_0000_792A_2E78,
      sre_pkg::OpByte, 8'h00, 1'b0, 1'b0},
    '{RowCfg, sre_pkg::CfgLength, 64'd4, sre_pkg::OpByte, 8'h00, 1'b0, 1'b0},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpByte, 8'h7A, 1'b0, 1'b0},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpByte, 8'h78, 1'b0, 1'b0},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpByte, 8'h00, 1'b0, 1'b0},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpByte, 8'h79, 1'b0, 1'b0},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpEnd, 8'h00, 1'b1, 1'b1},
    // "*$^": star, dollar and caret out of place are all literal
    '{RowCfg, sre_pkg::CfgFirstBytes, 64'h0000_0000_005E_242A,
      sre_pkg::OpByte, 8'h00, 1'b0, 1'b0},
    '{RowCfg, sre_pkg::CfgLength, 64'd3, sre_pkg::OpByte, 8'h00, 1'b0, 1'b0},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpByte, 8'h2A, 1'b0, 1'b0},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpByte, 8'h24, 1'b0, 1'b0},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpByte, 8'h5E, 1'b0, 1'b0},
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpEnd, 8'h00, 1'b1, 1'b1},
    // text left open across a pattern change
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpByte, 8'h71, 1'b0, 1'b0},
    // oversized length, pattern cut short by the zero byte at position 8
    '{RowCfg, sre_pkg::CfgFirstBytes, 64'hFFFF_FFFF_FFFF_FFFF,
      sre_pkg::OpByte, 8'h00, 1'b0, 1'b0},
    '{RowCfg, sre_pkg::CfgLastBytes, 64'h0, sre_pkg::OpByte, 8'h00, 1'b0, 1'b0},
    '{RowCfg, sre_pkg::CfgLength, 64'd31, sre_pkg::OpByte, 8'h00, 1'b0, 1'b0},
    // byte field on end of text is ignored
    '{RowItem, sre_pkg::CfgFirstBytes, 64'h0, sre_pkg::OpEnd, 8'hFF, 1'b0, 1'b0}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        op_in;
  logic [7:0]  byte_in;
  logic        out_valid;
  logic        out_ready;
  logic        matched;

  // Pattern registers as the bench last wrote them
  logic [63:0] pat_first;
  logic [63:0] pat_last;
  logic [4:0]  pat_len;
  // Matcher state mirrored by the predictor
  logic [16:0] live_pos;
  bit          text_seen;
  bit          hit_seen;

  bit match_q [$];

  int errors;
  int items_sent;
  int results_seen;
  int matches_seen;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_asks;
  int hold_seen;
  int hold_left;

  simple_regex_stream_matcher_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (op_in),
    .text_byte_i (byte_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .matched_o   (matched)
  );

  always #6 clk = ~clk;

  // Advance the mirrored matcher by one transaction; returns 1 when a verdict is due
  function automatic bit predict_match(input sre_pkg::op_e op, input logic [7:0] b,
                                       output bit verdict);
    logic [7:0]  pb [0:16];
    logic [63:0] w;
    logic [31:0] keep;
    logic [16:0] cur;
    logic [16:0] nxt;
    int unsigned plen;
    int unsigned k;
    bit          anchored;
    bit          star_next;
    bit          hit;
    verdict = 1'b0;
    plen = (32'(pat_len) > sre_pkg::MaxPattern) ? sre_pkg::MaxPattern : 32'(pat_len);
    for (k = 0; k <= sre_pkg::MaxPattern; k++) pb[k] = 8'h00;
    // a zero byte terminates the pattern early
    for (k = 0; k < plen; k++) begin
      w = (k < 8) ? pat_first : pat_last;
      pb[k] = w[8*(k%8) +: 8];
      if (pb[k] == 8'h00) begin
        plen = k;
        break;
      end
    end
    anchored = (plen > 0) && (pb[0] == sre_pkg::ChCaret);
    keep = (32'h1 << (plen + 1)) - 32'h1;
    cur = live_pos & keep[16:0];
    if (anchored) begin
      if (!text_seen) cur[1] = 1'b1;
    end else begin
      cur[0] = 1'b1;
    end
    // zero-length stars make the position two further live
    for (k = 0; k < plen; k++)
      if (cur[k] && (k + 1 < plen) && (pb[k+1] == sre_pkg::ChStar)) cur[k+2] = 1'b1;
    if (cur[plen]) hit_seen = 1'b1;
    if (op == sre_pkg::OpByte) begin
      nxt = '0;
      for (k = 0; k < plen; k++) begin
        if (cur[k]) begin
          hit = (pb[k] == sre_pkg::ChDot) || (pb[k] == b);
          star_next = (k + 1 < plen) && (pb[k+1] == sre_pkg::ChStar);
          if (star_next) begin
            if (hit) nxt[k] = 1'b1;
          end else if (!((k + 1 == plen) && (pb[k] == sre_pkg::ChDollar)) && hit) begin
            nxt[k+1] = 1'b1;
          end
        end
      end
      live_pos = nxt;
      text_seen = 1'b1;
      return 1'b0;
    end
    // a final dollar only matches at end of text
    for (k = 0; k < plen; k++)
      if (cur[k] && (k + 1 == plen) && (pb[k] == sre_pkg::ChDollar)) hit_seen = 1'b1;
    verdict = hit_seen;
    live_pos = '0;
    text_seen = 1'b0;
    hit_seen = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 35) return "a";
    if (r < 70) return "b";
    if (r < 85) return "c";
    if (r < 95) return 8'($urandom_range(255));
    case (r)
      95: return sre_pkg::ChStar;
      96: return sre_pkg::ChDot;
      97: return sre_pkg::ChDollar;
      default: return sre_pkg::ChCaret;
    endcase
  endfunction

  // One text transaction, with random sender idling in front of it
  task automatic send_item(input sre_pkg::op_e op, input logic [7:0] b, input bit typed,
                           input bit want);
    bit verdict;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op_in <= op;
    byte_in <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (predict_match(op, b, verdict)) match_q.push_back(typed ? want : verdict);
  endtask

  task automatic write_reg(input sre_pkg::cfg_idx_e idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sre_pkg::CfgFirstBytes: pat_first = data;
      sre_pkg::CfgLastBytes:  pat_last = data;
      sre_pkg::CfgLength:     pat_len = data[4:0];
      default: ;
    endcase
  endtask

  // Stop sending, let every verdict arrive and the last byte settle
  task automatic settle();
    in_valid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_random_pattern(input int ph);
    logic [127:0] bits;
    logic [7:0]   pb;
    logic [4:0]   len_f;
    int           n;
    int           k;
    int           r;
    bits = {$urandom, $urandom, $urandom, $urandom};
    if (ph == 0) begin
      bits = '0;
      len_f = 5'd0;
      n = 0;
    end else if (ph == 3) begin
      len_f = 5'd16;
      n = 16;
    end else if (ph == 6) begin
      bits = '1;
      len_f = 5'd31;
      n = 0;
    end else if (ph == 9) begin
      len_f = 5'($urandom_range(17, 31));
      n = 16;
    end else begin
      n = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      len_f = 5'(n);
    end
    // small alphabet so that texts match often
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 2) pb = 8'h00;
      else if (r < 10) pb = 8'($urandom_range(255));
      else if (r < 12) pb = sre_pkg::ChCaret;
      else if (r < 14) pb = sre_pkg::ChDollar;
      else if (r < 39) pb = "a";
      else if (r < 64) pb = "b";
      else if (r < 72) pb = "c";
      else if (r < 86) pb = sre_pkg::ChDot;
      else pb = sre_pkg::ChStar;
      if (k == 0 && $urandom_range(2) == 0) pb = sre_pkg::ChCaret;
      if (k == n - 1 && n > 1 && $urandom_range(2) == 0) pb = sre_pkg::ChDollar;
      bits[8*k +: 8] = pb;
    end
    write_reg(sre_pkg::CfgFirstBytes, bits[63:0]);
    write_reg(sre_pkg::CfgLastBytes, bits[127:64]);
    write_reg(sre_pkg::CfgLength, {59'b0, len_f});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_text();
    int n;
    n = ($urandom_range(19) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
    repeat (n) send_item(sre_pkg::OpByte, pick_text_byte(), 1'b0, 1'b0);
    send_item(sre_pkg::OpEnd, 8'($urandom_range(255)), 1'b0, 1'b0);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each verdict transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    bit want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (matched) matches_seen++;
      if (match_q.size() == 0) begin
        $display("%0t: verdict with none outstanding, expected none, actual %0b",
                 $time, matched);
        errors++;
      end else begin
        want = match_q.pop_front();
        if (matched !== want) begin
          $display("%0t: matched mismatch, expected %0b, actual %0b", $time, want, matched);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timed out, %0d verdicts outstanding", $time, match_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t row;
    bit       prev_cfg;
    bit       paused;
    int       i;
    int       ph;
    int       start;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = sre_pkg::CfgFirstBytes;
    cfg_data = '0;
    in_valid = 1'b0;
    op_in = sre_pkg::OpByte;
    byte_in = 8'h00;
    out_ready = 1'b0;
    pat_first = '0;
    pat_last = '0;
    pat_len = '0;
    live_pos = '0;
    text_seen = 1'b0;
    hit_seen = 1'b0;
    send_idle_pct = 20;
    recv_stall_pct = 20;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    prev_cfg = 1'b0;
    for (i = 0; i < NumDir; i++) begin
      row = DirRows[i];
      if (row.kind == RowCfg) begin
        if (!prev_cfg) settle();
        write_reg(row.idx, row.data);
      end else begin
        if (prev_cfg) cfg_valid <= 1'b0;
        send_item(row.op, row.tbyte, row.typed, row.want);
      end
      prev_cfg = (row.kind == RowCfg);
    end

    // random phases, each under a fresh pattern and idling mode
    for (ph = 0; ph < NumPhases; ph++) begin
      settle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      load_random_pattern(ph);
      if (ph == 4) hold_asks++;
      start = items_sent;
      paused = 1'b0;
      while (items_sent - start < PhaseItems) begin
        if ((ph == 4 || ph == 10) && !paused && items_sent - start >= PhaseItems / 2) begin
          settle();
          paused = 1'b1;
        end
        send_text();
      end
      // sometimes leave a text open across the next pattern change
      if ($urandom_range(1) == 1)
        repeat ($urandom_range(1, 3)) send_item(sre_pkg::OpByte, pick_text_byte(), 1'b0, 1'b0);
    end
    settle();
    repeat (5) @(posedge clk);

    $display("Sent %0d text transactions under %0d pattern settings and four idling modes.",
             items_sent, NumPhases + 5);
    $display("Checked %0d verdicts, %0d of them matches.", results_seen, matches_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### simple_regex_stream_matcher_unit.f
hw/rtl/sre_pkg.sv
hw/rtl/sre_decode.sv
hw/rtl/sre_cell.sv
hw/rtl/simple_regex_stream_matcher_unit.sv
bench/tb.sv
